// ----- hw/rtl/dfsom_pkg.sv -----
// dfsom_pkg: widths, types, register codes and index tables for the dipole
// edge fringe second-order map core
// no dependencies
package dfsom_pkg;

	// coordinate format, signed fixed point
	localparam int COORD_W   = 32;
	localparam int FRAC_BITS = 24;

	// exact coordinate product, rounded monomial, clamped monomial
	localparam int PROD_W = 2 * COORD_W;
	localparam int RND_W  = PROD_W + 1 - FRAC_BITS;
	localparam int MONO_W = (RND_W > 64) ? 64 : RND_W;

	// monomial split for the coefficient multipliers
	localparam int LO_W  = MONO_W / 2;
	localparam int HI_W  = MONO_W - LO_W;
	localparam int LOP_W = COORD_W + LO_W + 1;
	localparam int HIP_W = COORD_W + HI_W;

	// coefficient times monomial, accumulator, rounded accumulator
	localparam int TERM_W = COORD_W + MONO_W;
	localparam int SUM_W  = TERM_W + 4;
	localparam int RES_W  = SUM_W - FRAC_BITS;

	localparam int NUM_COORD = 4;
	localparam int NUM_MONO  = 7;
	localparam int NUM_TERM  = 10;
	localparam int NUM_LIN   = 2;
	localparam int NUM_PART  = 3;
	localparam int NUM_CFG   = 8;
	localparam int CFG_IDX_W = 3;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [MONO_W-1:0]  mono_t;
	typedef logic signed [LOP_W-1:0]   lop_t;
	typedef logic signed [HIP_W-1:0]   hip_t;
	typedef logic signed [TERM_W-1:0]  term_t;
	typedef logic signed [SUM_W-1:0]   sum_t;

	// configuration register index
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FX   = 3'd0,
		REG_FY   = 3'd1,
		REG_T111 = 3'd2,
		REG_T133 = 3'd3,
		REG_T211 = 3'd4,
		REG_T233 = 3'd5,
		REG_T234 = 3'd6,
		REG_T413 = 3'd7
	} cfg_reg_t;

	// coordinate slots
	localparam int CO_X  = 0;
	localparam int CO_PX = 1;
	localparam int CO_Y  = 2;
	localparam int CO_PY = 3;

	// monomial slots
	localparam int MN_XX  = 0;
	localparam int MN_XPX = 1;
	localparam int MN_YY  = 2;
	localparam int MN_YPY = 3;
	localparam int MN_XY  = 4;
	localparam int MN_XPY = 5;
	localparam int MN_PXY = 6;

	// coefficient-monomial term slots
	localparam int TM_T111_XX  = 0;
	localparam int TM_T133_YY  = 1;
	localparam int TM_T111_XPX = 2;
	localparam int TM_T234_YPY = 3;
	localparam int TM_T211_XX  = 4;
	localparam int TM_T233_YY  = 5;
	localparam int TM_T234_XY  = 6;
	localparam int TM_T234_XPY = 7;
	localparam int TM_T413_XY  = 8;
	localparam int TM_T133_PXY = 9;

	// linear focusing slots
	localparam int LIN_FX = 0;
	localparam int LIN_FY = 1;

	// operands of each monomial
	localparam int MONO_A [NUM_MONO] = '{CO_X, CO_X, CO_Y, CO_Y, CO_X, CO_X, CO_PX};
	localparam int MONO_B [NUM_MONO] = '{CO_X, CO_PX, CO_Y, CO_PY, CO_Y, CO_PY, CO_Y};

	// coefficient and monomial of each term
	localparam int TERM_COEF [NUM_TERM] = '{
		int'(REG_T111), int'(REG_T133), int'(REG_T111), int'(REG_T234), int'(REG_T211),
		int'(REG_T233), int'(REG_T234), int'(REG_T234), int'(REG_T413), int'(REG_T133)
	};
	localparam int TERM_MONO [NUM_TERM] = '{
		MN_XX, MN_YY, MN_XPX, MN_YPY, MN_XX, MN_YY, MN_XY, MN_XPY, MN_XY, MN_PXY
	};

	// round-half-up offsets and clamp limits
	localparam logic [PROD_W:0] HALF_PROD =
		{{(PROD_W - FRAC_BITS + 1){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
	localparam sum_t HALF_SUM =
		{{(SUM_W - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
	localparam mono_t MONO_MIN = {1'b1, {(MONO_W - 1){1'b0}}};
	localparam mono_t MONO_MAX = {1'b0, {(MONO_W - 1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_W - 1){1'b0}}};
	localparam coord_t COORD_MAX = {1'b0, {(COORD_W - 1){1'b1}}};

endpackage

// ----- hw/rtl/dipole_fringe_second_order_map_core.sv -----
// dipole_fringe_second_order_map_core: second-order dipole edge fringe map
// on one particle's transverse coordinates, seven-stage pipeline
// depends on dfsom_pkg
//
// Usage
//   Input channel in_valid/in_ready moves one word: pos_x, ang_x, pos_y, ang_y.
//   Output channel out_valid/out_ready moves one word: new_pos_x, new_ang_x,
//   new_pos_y, new_ang_y and saturated.
//   Coefficients are loaded through cfg_we/cfg_idx/cfg_wdata, one register per cycle;
//   the user loads them only while no word is in flight, which the block does not enforce.
//   out_valid rises when the accepted word has moved through stages 1 to 6 into the
//   stage 7 output register. Throughput is one word per cycle while out_ready
//   does not stall the pipe, set by the stages of coordinate multipliers, split
//   coefficient multipliers and adder tree that each word passes through.
//   Each stage loads when it is empty or when the stage after it moves, so an
//   empty stage anywhere lets a new word in while a result waits on the
//   output; with every stage full a stalled receiver holds the whole pipe and
//   in_ready drops in the same cycle.
//   Reset clears all stage valid bits and sets every coefficient to zero,
//   which makes the map the identity.
module dipole_fringe_second_order_map_core (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration
	input  logic                    cfg_we,
	input  logic [dfsom_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  dfsom_pkg::coord_t       cfg_wdata,
	// input channel
	input  logic                    in_valid,
	output logic                    in_ready,
	input  dfsom_pkg::coord_t       pos_x,
	input  dfsom_pkg::coord_t       ang_x,
	input  dfsom_pkg::coord_t       pos_y,
	input  dfsom_pkg::coord_t       ang_y,
	// output channel
	output logic                    out_valid,
	input  logic                    out_ready,
	output dfsom_pkg::coord_t       new_pos_x,
	output dfsom_pkg::coord_t       new_ang_x,
	output dfsom_pkg::coord_t       new_pos_y,
	output dfsom_pkg::coord_t       new_ang_y,
	output logic                    saturated
);

	// coefficient registers
	dfsom_pkg::coord_t coef_q [dfsom_pkg::NUM_CFG];

	// stage valid bits and load enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7;

	// pipeline payload
	dfsom_pkg::coord_t coord_in [dfsom_pkg::NUM_COORD];
	dfsom_pkg::coord_t coord_s1 [dfsom_pkg::NUM_COORD];
	dfsom_pkg::coord_t coord_s2 [dfsom_pkg::NUM_COORD];
	dfsom_pkg::coord_t coord_s3 [dfsom_pkg::NUM_COORD];
	dfsom_pkg::coord_t coord_s4 [dfsom_pkg::NUM_COORD];
	dfsom_pkg::prod_t  prod_s1 [dfsom_pkg::NUM_MONO];
	dfsom_pkg::prod_t  lin_s1 [dfsom_pkg::NUM_LIN];
	dfsom_pkg::prod_t  lin_s2 [dfsom_pkg::NUM_LIN];
	dfsom_pkg::prod_t  lin_s3 [dfsom_pkg::NUM_LIN];
	dfsom_pkg::prod_t  lin_s4 [dfsom_pkg::NUM_LIN];
	dfsom_pkg::mono_t  mono_d [dfsom_pkg::NUM_MONO];
	dfsom_pkg::mono_t  mono_s2 [dfsom_pkg::NUM_MONO];
	logic [dfsom_pkg::PROD_W:0]  rnd_p [dfsom_pkg::NUM_MONO];
	logic [dfsom_pkg::RND_W-1:0] rnd_v [dfsom_pkg::NUM_MONO];
	logic msat_d, msat_s2, msat_s3, msat_s4, msat_s5, msat_s6;
	dfsom_pkg::lop_t   lop_s3 [dfsom_pkg::NUM_TERM];
	dfsom_pkg::hip_t   hip_s3 [dfsom_pkg::NUM_TERM];
	dfsom_pkg::term_t  term_s4 [dfsom_pkg::NUM_TERM];
	dfsom_pkg::sum_t   part_s5 [dfsom_pkg::NUM_COORD][dfsom_pkg::NUM_PART];
	dfsom_pkg::sum_t   sum_s6 [dfsom_pkg::NUM_COORD];
	logic [dfsom_pkg::RES_W-1:0] res_d [dfsom_pkg::NUM_COORD];
	dfsom_pkg::coord_t out_d [dfsom_pkg::NUM_COORD];
	logic              osat_d;
	dfsom_pkg::coord_t out_s7 [dfsom_pkg::NUM_COORD];
	logic              sat_s7;

	// coefficient writes, unknown bits above the register width never arrive
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < dfsom_pkg::NUM_CFG; k++) begin
				coef_q[k] <= '0;
			end
		end else if (cfg_we) begin
			unique case (dfsom_pkg::cfg_reg_t'(cfg_idx))
				dfsom_pkg::REG_FX:   coef_q[dfsom_pkg::REG_FX]   <= cfg_wdata;
				dfsom_pkg::REG_FY:   coef_q[dfsom_pkg::REG_FY]   <= cfg_wdata;
				dfsom_pkg::REG_T111: coef_q[dfsom_pkg::REG_T111] <= cfg_wdata;
				dfsom_pkg::REG_T133: coef_q[dfsom_pkg::REG_T133] <= cfg_wdata;
				dfsom_pkg::REG_T211: coef_q[dfsom_pkg::REG_T211] <= cfg_wdata;
				dfsom_pkg::REG_T233: coef_q[dfsom_pkg::REG_T233] <= cfg_wdata;
				dfsom_pkg::REG_T234: coef_q[dfsom_pkg::REG_T234] <= cfg_wdata;
				dfsom_pkg::REG_T413: coef_q[dfsom_pkg::REG_T413] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// a stage loads when empty or when its successor moves
	assign en_s7    = !v_s7 || out_ready;
	assign en_s6    = !v_s6 || en_s7;
	assign en_s5    = !v_s5 || en_s6;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
		end
	end

	assign coord_in[dfsom_pkg::CO_X]  = pos_x;
	assign coord_in[dfsom_pkg::CO_PX] = ang_x;
	assign coord_in[dfsom_pkg::CO_Y]  = pos_y;
	assign coord_in[dfsom_pkg::CO_PY] = ang_y;

	// stage 1: exact coordinate products and linear focusing products
	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int k = 0; k < dfsom_pkg::NUM_COORD; k++) begin
				coord_s1[k] <= coord_in[k];
			end
			for (int k = 0; k < dfsom_pkg::NUM_MONO; k++) begin
				prod_s1[k] <= coord_in[dfsom_pkg::MONO_A[k]] * coord_in[dfsom_pkg::MONO_B[k]];
			end
			lin_s1[dfsom_pkg::LIN_FX] <= coef_q[dfsom_pkg::REG_FX] * pos_x;
			lin_s1[dfsom_pkg::LIN_FY] <= coef_q[dfsom_pkg::REG_FY] * pos_y;
		end
	end

	// round monomials half up and clip to the monomial range
	always_comb begin
		msat_d = 1'b0;
		for (int k = 0; k < dfsom_pkg::NUM_MONO; k++) begin
			rnd_p[k] = {prod_s1[k][dfsom_pkg::PROD_W-1], prod_s1[k]} + dfsom_pkg::HALF_PROD;
			rnd_v[k] = rnd_p[k][dfsom_pkg::PROD_W:dfsom_pkg::FRAC_BITS];
			if ((&rnd_v[k][dfsom_pkg::RND_W-1:dfsom_pkg::MONO_W-1])
					|| !(|rnd_v[k][dfsom_pkg::RND_W-1:dfsom_pkg::MONO_W-1])) begin
				mono_d[k] = rnd_v[k][dfsom_pkg::MONO_W-1:0];
			end else begin
				mono_d[k] = rnd_v[k][dfsom_pkg::RND_W-1] ? dfsom_pkg::MONO_MIN
					: dfsom_pkg::MONO_MAX;
				msat_d = 1'b1;
			end
		end
	end

	// stage 2: rounded monomials
	always_ff @(posedge clk) begin
		if (en_s2) begin
			coord_s2 <= coord_s1;
			lin_s2   <= lin_s1;
			mono_s2  <= mono_d;
			msat_s2  <= msat_d;
		end
	end

	// stage 3: coefficient times low and high halves of each monomial
	always_ff @(posedge clk) begin
		if (en_s3) begin
			coord_s3 <= coord_s2;
			lin_s3   <= lin_s2;
			msat_s3  <= msat_s2;
			for (int k = 0; k < dfsom_pkg::NUM_TERM; k++) begin
				lop_s3[k] <= coef_q[dfsom_pkg::TERM_COEF[k]] * $signed({1'b0,
					mono_s2[dfsom_pkg::TERM_MONO[k]][dfsom_pkg::LO_W-1:0]});
				hip_s3[k] <= coef_q[dfsom_pkg::TERM_COEF[k]] * $signed(
					mono_s2[dfsom_pkg::TERM_MONO[k]][dfsom_pkg::MONO_W-1:dfsom_pkg::LO_W]);
			end
		end
	end

	// stage 4: recombine the halves into exact terms
	always_ff @(posedge clk) begin
		if (en_s4) begin
			coord_s4 <= coord_s3;
			lin_s4   <= lin_s3;
			msat_s4  <= msat_s3;
			for (int k = 0; k < dfsom_pkg::NUM_TERM; k++) begin
				term_s4[k] <= (dfsom_pkg::term_t'(hip_s3[k]) <<< dfsom_pkg::LO_W)
					+ dfsom_pkg::term_t'(lop_s3[k]);
			end
		end
	end

	// stage 5: first adder level, aligned base plus signed and doubled terms
	always_ff @(posedge clk) begin
		if (en_s5) begin
			msat_s5 <= msat_s4;
			// x
			part_s5[dfsom_pkg::CO_X][0] <=
				(dfsom_pkg::sum_t'(coord_s4[dfsom_pkg::CO_X]) <<< dfsom_pkg::FRAC_BITS)
				+ dfsom_pkg::sum_t'(term_s4[dfsom_pkg::TM_T111_XX]);
			part_s5[dfsom_pkg::CO_X][1] <= dfsom_pkg::sum_t'(term_s4[dfsom_pkg::TM_T133_YY]);
			part_s5[dfsom_pkg::CO_X][2] <= '0;
			// px
			part_s5[dfsom_pkg::CO_PX][0] <=
				(dfsom_pkg::sum_t'(coord_s4[dfsom_pkg::CO_PX]) <<< dfsom_pkg::FRAC_BITS)
				+ dfsom_pkg::sum_t'(lin_s4[dfsom_pkg::LIN_FX]);
			part_s5[dfsom_pkg::CO_PX][1] <=
				(dfsom_pkg::sum_t'(term_s4[dfsom_pkg::TM_T234_YPY])
				- dfsom_pkg::sum_t'(term_s4[dfsom_pkg::TM_T111_XPX])) <<< 1;
			part_s5[dfsom_pkg::CO_PX][2] <=
				dfsom_pkg::sum_t'(term_s4[dfsom_pkg::TM_T211_XX])
				+ dfsom_pkg::sum_t'(term_s4[dfsom_pkg::TM_T233_YY]);
			// y
			part_s5[dfsom_pkg::CO_Y][0] <=
				(dfsom_pkg::sum_t'(coord_s4[dfsom_pkg::CO_Y]) <<< dfsom_pkg::FRAC_BITS)
				- (dfsom_pkg::sum_t'(term_s4[dfsom_pkg::TM_T234_XY]) <<< 1);
			part_s5[dfsom_pkg::CO_Y][1] <= '0;
			part_s5[dfsom_pkg::CO_Y][2] <= '0;
			// py
			part_s5[dfsom_pkg::CO_PY][0] <=
				(dfsom_pkg::sum_t'(coord_s4[dfsom_pkg::CO_PY]) <<< dfsom_pkg::FRAC_BITS)
				- dfsom_pkg::sum_t'(lin_s4[dfsom_pkg::LIN_FY]);
			part_s5[dfsom_pkg::CO_PY][1] <=
				(dfsom_pkg::sum_t'(term_s4[dfsom_pkg::TM_T234_XPY])
				+ dfsom_pkg::sum_t'(term_s4[dfsom_pkg::TM_T413_XY])) <<< 1;
			part_s5[dfsom_pkg::CO_PY][2] <=
				-(dfsom_pkg::sum_t'(term_s4[dfsom_pkg::TM_T133_PXY]) <<< 1);
		end
	end

	// stage 6: final sum with the rounding half folded in
	always_ff @(posedge clk) begin
		if (en_s6) begin
			msat_s6 <= msat_s5;
			for (int k = 0; k < dfsom_pkg::NUM_COORD; k++) begin
				sum_s6[k] <= part_s5[k][0] + part_s5[k][1] + part_s5[k][2]
					+ dfsom_pkg::HALF_SUM;
			end
		end
	end

	// drop fraction bits and clip to the coordinate range
	always_comb begin
		osat_d = msat_s6;
		for (int k = 0; k < dfsom_pkg::NUM_COORD; k++) begin
			res_d[k] = sum_s6[k][dfsom_pkg::SUM_W-1:dfsom_pkg::FRAC_BITS];
			if ((&res_d[k][dfsom_pkg::RES_W-1:dfsom_pkg::COORD_W-1])
					|| !(|res_d[k][dfsom_pkg::RES_W-1:dfsom_pkg::COORD_W-1])) begin
				out_d[k] = res_d[k][dfsom_pkg::COORD_W-1:0];
			end else begin
				out_d[k] = res_d[k][dfsom_pkg::RES_W-1] ? dfsom_pkg::COORD_MIN
					: dfsom_pkg::COORD_MAX;
				osat_d = 1'b1;
			end
		end
	end

	// stage 7: output register
	always_ff @(posedge clk) begin
		if (en_s7) begin
			out_s7 <= out_d;
			sat_s7 <= osat_d;
		end
	end

	assign out_valid = v_s7;
	assign new_pos_x = out_s7[dfsom_pkg::CO_X];
	assign new_ang_x = out_s7[dfsom_pkg::CO_PX];
	assign new_pos_y = out_s7[dfsom_pkg::CO_Y];
	assign new_ang_y = out_s7[dfsom_pkg::CO_PY];
	assign saturated = sat_s7;

`ifndef SYNTH
	// an empty output stage never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked while output stage empty");

	// a held middle stage keeps its word
	a_hold_s4: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !en_s4) |=> v_s4)
		else $error("stage 4 word lost during stall");

	// a new result only comes from a full stage 6
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(v_s6))
		else $error("output valid without a word in stage 6");

	// monomials cannot clip when their rounded width fits
	a_mono_range: assert property (@(posedge clk) disable iff (!arst_n)
		(dfsom_pkg::RND_W > dfsom_pkg::MONO_W) || !(v_s2 && msat_s2))
		else $error("monomial clipped at a width where it cannot overflow");
`endif

endmodule

// ----- dv/dfsom_map_checker.sv -----
// dfsom_map_checker: watches the coefficient port and both word channels of the
// dipole fringe map core, predicts each result word and compares it
// depends on dfsom_pkg
`timescale 1ns / 100ps

module dfsom_map_checker
	import dfsom_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  coord_t               cfg_wdata,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  coord_t               pos_x,
	input  coord_t               ang_x,
	input  coord_t               pos_y,
	input  coord_t               ang_y,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  coord_t               new_pos_x,
	input  coord_t               new_ang_x,
	input  coord_t               new_pos_y,
	input  coord_t               new_ang_y,
	input  logic                 saturated,
	output int                   fail_count,
	output int                   words_pending
);

	// wide enough for every exact product and sum at these widths
	typedef logic signed [127:0] wide_t;

	typedef struct packed {
		coord_t pos_x;
		coord_t ang_x;
		coord_t pos_y;
		coord_t ang_y;
		logic   sat;
	} edge_word_t;

	// monomial slots
	localparam int SQ_X = 0;
	localparam int X_PX = 1;
	localparam int SQ_Y = 2;
	localparam int Y_PY = 3;
	localparam int X_Y  = 4;
	localparam int X_PY = 5;
	localparam int PX_Y = 6;
	localparam int MONO_BOUND = 64;
	localparam int LOG_LIMIT  = 40;

	coord_t     coef [NUM_CFG];
	edge_word_t edge_words_q [$];
	int         failures = 0;
	int         reported = 0;
	int         queued = 0;

	assign fail_count    = failures;
	assign words_pending = queued;

	// round half up to the coordinate fraction
	function automatic wide_t round_frac(wide_t v);
		return (v + (wide_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
	endfunction

	function automatic wide_t top_of(int n);
		return (wide_t'(1) <<< (n - 1)) - 1;
	endfunction

	function automatic bit out_of_range(wide_t v, int n);
		return (v > top_of(n)) || (v < -top_of(n) - 1);
	endfunction

	function automatic wide_t clip(wide_t v, int n);
		if (v > top_of(n))
			return top_of(n);
		if (v < -top_of(n) - 1)
			return -top_of(n) - 1;
		return v;
	endfunction

	// second-order edge map of one particle under the current coefficients
	function automatic edge_word_t predict_edge(coord_t x_in, coord_t px_in,
						    coord_t y_in, coord_t py_in);
		wide_t      x, px, y, py, r;
		wide_t      mono [7];
		wide_t      k [NUM_CFG];
		wide_t      s [4];
		coord_t     res [4];
		bit         clipped;
		edge_word_t w;
		x  = wide_t'(x_in);
		px = wide_t'(px_in);
		y  = wide_t'(y_in);
		py = wide_t'(py_in);
		foreach (coef[i])
			k[i] = wide_t'(coef[i]);
		clipped = 1'b0;

		// monomials of the incoming coordinates, rounded and held to 64 bits
		mono[SQ_X] = x * x;
		mono[X_PX] = x * px;
		mono[SQ_Y] = y * y;
		mono[Y_PY] = y * py;
		mono[X_Y]  = x * y;
		mono[X_PY] = x * py;
		mono[PX_Y] = px * y;
		foreach (mono[i]) begin
			r = round_frac(mono[i]);
			clipped |= out_of_range(r, MONO_BOUND);
			mono[i] = clip(r, MONO_BOUND);
		end

		// exact sums at twice the fraction
		s[0] = (x <<< FRAC_BITS) + k[REG_T111] * mono[SQ_X] + k[REG_T133] * mono[SQ_Y];
		s[1] = (px <<< FRAC_BITS) + k[REG_FX] * x - 2 * k[REG_T111] * mono[X_PX]
			+ 2 * k[REG_T234] * mono[Y_PY] + k[REG_T211] * mono[SQ_X]
			+ k[REG_T233] * mono[SQ_Y];
		s[2] = (y <<< FRAC_BITS) - 2 * k[REG_T234] * mono[X_Y];
		s[3] = (py <<< FRAC_BITS) - k[REG_FY] * y + 2 * k[REG_T234] * mono[X_PY]
			+ 2 * k[REG_T413] * mono[X_Y] - 2 * k[REG_T133] * mono[PX_Y];

		// one rounding, then saturation to the coordinate width
		foreach (s[i]) begin
			r = round_frac(s[i]);
			clipped |= out_of_range(r, COORD_W);
			res[i] = coord_t'(clip(r, COORD_W));
		end
		w.pos_x = res[0];
		w.ang_x = res[1];
		w.pos_y = res[2];
		w.ang_y = res[3];
		w.sat   = clipped;
		return w;
	endfunction

	// keep the log short once many fields mismatch
	task automatic check_field(string what, logic [COORD_W-1:0] want,
				   logic [COORD_W-1:0] got);
		if (want !== got) begin
			failures++;
			if (reported < LOG_LIMIT)
				$display("%0t: %s expected %h, got %h", $time, what, want, got);
			reported++;
		end
	endtask

	// compare result words, then track coefficient writes and accepted words
	always @(posedge clk or negedge arst_n) begin
		edge_word_t want;
		if (!arst_n) begin
			foreach (coef[i])
				coef[i] = '0;
			edge_words_q.delete();
			queued = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (edge_words_q.size() == 0) begin
					failures++;
					if (reported < LOG_LIMIT)
						$display("%0t: result word expected none, got %h %h %h %h %b",
							 $time, new_pos_x, new_ang_x, new_pos_y, new_ang_y,
							 saturated);
					reported++;
				end else begin
					want = edge_words_q.pop_front();
					check_field("new_pos_x", want.pos_x, new_pos_x);
					check_field("new_ang_x", want.ang_x, new_ang_x);
					check_field("new_pos_y", want.pos_y, new_pos_y);
					check_field("new_ang_y", want.ang_y, new_ang_y);
					check_field("saturated", {{(COORD_W - 1){1'b0}}, want.sat},
						    {{(COORD_W - 1){1'b0}}, saturated});
				end
			end
			if (cfg_we)
				coef[cfg_idx] = cfg_wdata;
			if (in_valid && in_ready)
				edge_words_q.push_back(predict_edge(pos_x, ang_x, pos_y, ang_y));
			queued = edge_words_q.size();
		end
	end

endmodule

// ----- dv/testbench.sv -----
// testbench: drives coefficient loads and particle words into the dipole
// fringe map core under several idle patterns; checking is in dfsom_map_checker
// depends on dfsom_pkg, dipole_fringe_second_order_map_core, dfsom_map_checker
`timescale 1ns / 100ps

module testbench;
	import dfsom_pkg::*;

	localparam int HALF_PERIOD = 4;
	localparam int PIPE_DEPTH  = 7;
	localparam int HOLD_CYCLES = 160;
	localparam int PHASE_WORDS = 112;
	localparam int NUM_PHASES  = 8;
	localparam coord_t UNIT    = coord_t'(1) <<< FRAC_BITS;

	typedef enum {CS_ZERO, CS_TYPICAL, CS_MAX, CS_MIN, CS_WILD} coef_style_t;
	typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	localparam coef_style_t PHASE_COEFS [NUM_PHASES] = '{
		CS_TYPICAL, CS_WILD, CS_TYPICAL, CS_MIN, CS_TYPICAL, CS_MAX, CS_TYPICAL, CS_ZERO
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	coord_t               cfg_wdata = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	coord_t               pos_x = '0;
	coord_t               ang_x = '0;
	coord_t               pos_y = '0;
	coord_t               ang_y = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	coord_t               new_pos_x;
	coord_t               new_ang_x;
	coord_t               new_pos_y;
	coord_t               new_ang_y;
	logic                 saturated;
	int                   fail_count;
	int                   words_pending;

	logic in_fire_q = 1'b0;
	int   idle_pct = 0;
	int   stall_pct = 0;
	int   hold_req = 0;
	int   hold_seen = 0;
	int   hold_left = 0;

	dipole_fringe_second_order_map_core dut (.*);

	dfsom_map_checker checker_i (.*);

	always #(HALF_PERIOD) clk = ~clk;

	// input acceptance seen at the rising edge, read at the falling edge
	always @(posedge clk)
		in_fire_q <= in_valid && in_ready;

	// receiver: random stalls, or a long hold-off on request
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic coord_t small_value(int bits);
		coord_t v;
		v = coord_t'($urandom >> (32 - bits));
		return $urandom_range(1) ? -v : v;
	endfunction

	function automatic coord_t pick_coef(coef_style_t style);
		case (style)
			CS_ZERO: return '0;
			CS_MAX:  return COORD_MAX;
			CS_MIN:  return COORD_MIN;
			CS_WILD: return coord_t'($urandom);
			default: return small_value($urandom_range(26, 10));
		endcase
	endfunction

	// mostly beam-like coordinates, some full range and some corners
	function automatic coord_t pick_coord();
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(6))
					0: return COORD_MIN;
					1: return COORD_MAX;
					2: return '0;
					3: return -coord_t'(1);
					4: return coord_t'(1);
					5: return UNIT;
					default: return -UNIT;
				endcase
			end
			1, 2: return coord_t'($urandom);
			default: return small_value($urandom_range(27, 1));
		endcase
	endfunction

	task automatic set_idle(idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin idle_pct = 0;  stall_pct <= 0;  end
			IDLE_SEND: begin idle_pct = 69; stall_pct <= 0;  end
			IDLE_RECV: begin idle_pct = 0;  stall_pct <= 69; end
			default:   begin idle_pct = 22; stall_pct <= 22; end
		endcase
	endtask

	// one write per register, in index order
	task automatic load_coefs(coef_style_t style);
		cfg_reg_t r;
		r = r.first();
		do begin
			cfg_we    <= 1'b1;
			cfg_idx   <= r;
			cfg_wdata <= pick_coef(style);
			@(negedge clk);
			r = r.next();
		end while (r != r.first());
		cfg_we <= 1'b0;
	endtask

	task automatic send_word(coord_t x, coord_t px, coord_t y, coord_t py);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pos_x    <= x;
		ang_x    <= px;
		pos_y    <= y;
		ang_y    <= py;
		do
			@(negedge clk);
		while (!in_fire_q);
	endtask

	// wait until every word is out and the pipe has emptied
	task automatic drain();
		in_valid <= 1'b0;
		while (words_pending != 0)
			@(negedge clk);
		repeat (PIPE_DEPTH + 4) @(negedge clk);
	endtask

	task automatic send_corners();
		send_word('0, '0, '0, '0);
		send_word(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
		send_word(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
		send_word(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
		send_word(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
		send_word(UNIT, UNIT, UNIT, UNIT);
		send_word(-UNIT, -UNIT, -UNIT, -UNIT);
		send_word(-coord_t'(1), -coord_t'(1), -coord_t'(1), -coord_t'(1));
	endtask

	// stimulus and verdict
	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// corners under reset coefficients (identity), typical, then all-max
		set_idle(IDLE_NONE);
		send_corners();
		drain();
		load_coefs(CS_TYPICAL);
		send_corners();
		drain();
		load_coefs(CS_MAX);
		send_corners();
		drain();

		// random phases; the first one holds the receiver off to fill the pipe
		for (int p = 0; p < NUM_PHASES; p++) begin
			load_coefs(PHASE_COEFS[p]);
			set_idle(idle_mode_t'(p % 4));
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (p == 0 && n == 24)
					hold_req <= hold_req + 1;
				send_word(pick_coord(), pick_coord(), pick_coord(), pick_coord());
			end
			drain();
		end

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// end the run with failures if it hangs
	initial begin
		#(2_000_000);
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- dipole_fringe_second_order_map_core.f -----
hw/rtl/dfsom_pkg.sv
hw/rtl/dipole_fringe_second_order_map_core.sv
dv/dfsom_map_checker.sv
dv/testbench.sv
